// ----- rtl/core/zdp_pkg.sv -----
// zdp_pkg: shared types, constants and helpers for zone depth to point projection
// used by zdp_front, zdp_queue, zdp_back and the top level; no dependencies
package zdp_pkg;

   localparam int MAX_COLUMNS = 16;
   localparam int MAX_ROWS    = 16;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int COUNT_W     = 5;
   localparam int DIST_W      = 15;
   localparam int TAN_W       = 16;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAN_X     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAN_Y     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_H     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_V     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PERP      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR    = 4'd7;

   typedef struct packed {
      logic [COUNT_W-1:0] cols;
      logic [COUNT_W-1:0] rows;
      logic [TAN_W-1:0]   tan_x;
      logic [TAN_W-1:0]   tan_y;
      logic               inv_h;
      logic               inv_v;
      logic               perp;
      logic [7:0]         sensor;
   } cfg_type;

   typedef struct packed {
      logic              dist_valid;
      logic [DIST_W-1:0] dist_mm;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [7:0]        zone;
      logic              frame_last;
   } zdp_entry_type;

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                      input logic [COUNT_W-1:0] maxv);
      logic [COUNT_W-1:0] r;
      if (v == '0)
         r = COUNT_W'(1);
      else if (v > maxv)
         r = maxv;
      else
         r = v;
      return r;
   endfunction

endpackage

// ----- rtl/core/zdp_front.sv -----
// zdp_front: zone column/row counters, zone number, frame end flag and
// classification of the distance; depends on zdp_pkg
module zdp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  zdp_pkg::cfg_type        cfg,
   input  logic                    push,
   input  logic signed [15:0]      zone_distance,
   input  logic                    frame_start,
   output zdp_pkg::zdp_entry_type  entry
);

   logic [zdp_pkg::COL_W-1:0]   col_ff, col_in, col_eff;
   logic [zdp_pkg::ROW_W-1:0]   row_ff, row_in, row_eff;
   logic [zdp_pkg::COUNT_W-1:0] col_next, row_next;
   logic [8:0]                  zone_full;

   always_comb begin
      col_eff = frame_start ? '0 : col_ff;
      row_eff = frame_start ? '0 : row_ff;
      if ({1'b0, col_eff} >= cfg.cols) col_eff = '0;
      if ({1'b0, row_eff} >= cfg.rows) row_eff = '0;

      zone_full = 9'(row_eff * cfg.cols) + 9'(col_eff);

      entry.dist_valid = !zone_distance[15] && (zone_distance != '0);
      entry.dist_mm    = zone_distance[zdp_pkg::DIST_W-1:0];
      entry.col        = col_eff;
      entry.row        = row_eff;
      entry.zone       = zone_full[7:0];
      entry.frame_last = ({1'b0, col_eff} == cfg.cols - 1'b1)
                         && ({1'b0, row_eff} == cfg.rows - 1'b1);

      // raster advance, column fastest
      col_next = {1'b0, col_eff} + 1'b1;
      row_next = {1'b0, row_eff} + 1'b1;
      col_in   = col_next[zdp_pkg::COL_W-1:0];
      row_in   = row_eff;
      if (col_next >= cfg.cols) begin
         col_in = '0;
         row_in = (row_next >= cfg.rows) ? '0 : row_next[zdp_pkg::ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (push) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ----- rtl/core/zdp_queue.sv -----
// zdp_queue: two-entry item queue between front and back
// depends on zdp_pkg for the entry type
module zdp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  zdp_pkg::zdp_entry_type  push_entry,
   input  logic                    pop,
   output zdp_pkg::zdp_entry_type  head,
   output logic                    empty,
   output logic                    full
);

   zdp_pkg::zdp_entry_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ----- rtl/core/zdp_back.sv -----
// zdp_back: slope division, hypotenuse correction by reciprocal and bit-serial
// square root, point scaling and the result register; depends on zdp_pkg
module zdp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  zdp_pkg::cfg_type        cfg,
   input  zdp_pkg::zdp_entry_type  head,
   input  logic                    empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [19:0]      rsp_point_x,
   output logic signed [19:0]      rsp_point_y,
   output logic [14:0]             rsp_point_z,
   output logic                    rsp_point_valid,
   output logic [7:0]              rsp_zone_number,
   output logic [7:0]              rsp_source_sensor,
   output logic                    rsp_frame_last
);

   localparam int SLOPE_STEPS = 21;
   localparam int LIM_STEPS   = 33;
   localparam logic [15:0] C_MAX = 16'd32768;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_SLOPE_DIV, ST_SQ_X, ST_SQ_Y,
      ST_LIM_DIV, ST_ROOT, ST_SCALE_D, ST_SCALE_XY, ST_DONE
   } state_type;

   state_type state_ff;
   zdp_pkg::zdp_entry_type e_ff;
   logic [5:0]  step_ff;
   logic [20:0] nx_ff, ny_ff;
   logic [5:0]  rx_ff, ry_ff;
   logic [5:0]  denx_ff, deny_ff;
   logic        negx_ff, negy_ff;
   logic [33:0] q_ff, rem_ff;
   logic [32:0] lim_ff;
   logic [15:0] c_ff;
   logic [3:0]  bidx_ff;
   logic [14:0] dist_ff;
   logic signed [19:0] x_ff, y_ff;

   // slope setup
   logic signed [5:0] kx, ky;
   logic [3:0]  kx_mag, ky_mag;
   logic [19:0] mx, my;
   // slope squares
   logic [31:0] sq_x, sq_y;
   // restoring division steps
   logic [6:0]  tx, ty;
   logic        gex, gey;
   logic [34:0] tl;
   logic        gel;
   // root step
   logic [15:0] try_c;
   logic [16:0] t_odd;
   logic [33:0] t_sq;
   logic        keep;
   // scaling
   logic [30:0] dc;
   logic [31:0] dcr;
   logic [30:0] px, py;
   logic [30:0] pxr, pyr;

   always_comb begin
      kx     = 6'({1'b0, e_ff.col, 1'b1}) - 6'(cfg.cols);
      ky     = 6'({1'b0, e_ff.row, 1'b1}) - 6'(cfg.rows);
      kx_mag = kx[5] ? 4'(-kx) : kx[3:0];
      ky_mag = ky[5] ? 4'(-ky) : ky[3:0];
      mx     = kx_mag * cfg.tan_x;
      my     = ky_mag * cfg.tan_y;

      sq_x = nx_ff[15:0] * nx_ff[15:0];
      sq_y = ny_ff[15:0] * ny_ff[15:0];

      tx  = {rx_ff, nx_ff[20]};
      ty  = {ry_ff, ny_ff[20]};
      gex = tx >= {1'b0, denx_ff};
      gey = ty >= {1'b0, deny_ff};

      tl  = {rem_ff, 1'b0};
      gel = tl >= {1'b0, q_ff};

      try_c = c_ff | (16'd1 << bidx_ff);
      t_odd = {try_c, 1'b0} - 17'd1;
      t_sq  = t_odd * t_odd;
      keep  = (try_c <= C_MAX) && (t_sq <= {1'b0, lim_ff});

      dc  = e_ff.dist_mm * c_ff;
      dcr = 32'(dc) + 32'd16384;

      px  = dist_ff * nx_ff[15:0];
      py  = dist_ff * ny_ff[15:0];
      pxr = px + 31'd2048;
      pyr = py + 31'd2048;
   end

   assign pop = (state_ff == ST_IDLE) && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && (!rsp_valid || !rsp_stall))
            rsp_valid <= 1'b1;
         else if (rsp_valid && !rsp_stall)
            rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (!empty) begin
                  e_ff <= head;
                  x_ff <= '0;
                  y_ff <= '0;
                  dist_ff <= '0;
                  state_ff <= head.dist_valid ? ST_SETUP : ST_DONE;
               end
            end
            ST_SETUP: begin
               nx_ff   <= {mx, 1'b0} + 21'(cfg.cols);
               ny_ff   <= {my, 1'b0} + 21'(cfg.rows);
               denx_ff <= {cfg.cols, 1'b0};
               deny_ff <= {cfg.rows, 1'b0};
               rx_ff   <= '0;
               ry_ff   <= '0;
               negx_ff <= kx[5] ^ cfg.inv_h;
               negy_ff <= ky[5] ^ cfg.inv_v;
               step_ff <= '0;
               state_ff <= ST_SLOPE_DIV;
            end
            ST_SLOPE_DIV: begin
               rx_ff <= gex ? 6'(tx - {1'b0, denx_ff}) : tx[5:0];
               ry_ff <= gey ? 6'(ty - {1'b0, deny_ff}) : ty[5:0];
               nx_ff <= {nx_ff[19:0], gex};
               ny_ff <= {ny_ff[19:0], gey};
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'(SLOPE_STEPS - 1)) begin
                  if (cfg.perp) begin
                     dist_ff  <= e_ff.dist_mm;
                     state_ff <= ST_SCALE_XY;
                  end else begin
                     state_ff <= ST_SQ_X;
                  end
               end
            end
            ST_SQ_X: begin
               q_ff <= 34'(1 << 24) + 34'(sq_x);
               state_ff <= ST_SQ_Y;
            end
            ST_SQ_Y: begin
               q_ff    <= q_ff + 34'(sq_y);
               // 2^56 / q: top dividend bits 2^23 are already below q
               rem_ff  <= 34'(1 << 23);
               lim_ff  <= '0;
               step_ff <= '0;
               state_ff <= ST_LIM_DIV;
            end
            ST_LIM_DIV: begin
               rem_ff  <= gel ? 34'(tl - {1'b0, q_ff}) : tl[33:0];
               lim_ff  <= {lim_ff[31:0], gel};
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'(LIM_STEPS - 1)) begin
                  c_ff     <= '0;
                  bidx_ff  <= 4'd15;
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               // largest c with (2c-1)^2 <= floor(2^56/q), one bit per cycle
               if (keep) c_ff <= try_c;
               bidx_ff <= bidx_ff - 4'd1;
               if (bidx_ff == 4'd0) state_ff <= ST_SCALE_D;
            end
            ST_SCALE_D: begin
               dist_ff  <= dcr[29:15];
               state_ff <= ST_SCALE_XY;
            end
            ST_SCALE_XY: begin
               x_ff <= negx_ff ? -20'(pxr[30:12]) : 20'(pxr[30:12]);
               y_ff <= negy_ff ? -20'(pyr[30:12]) : 20'(pyr[30:12]);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_point_x       <= x_ff;
                  rsp_point_y       <= y_ff;
                  rsp_point_z       <= dist_ff;
                  rsp_point_valid   <= e_ff.dist_valid;
                  rsp_zone_number   <= e_ff.zone;
                  rsp_source_sensor <= cfg.sensor;
                  rsp_frame_last    <= e_ff.frame_last;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |->
         rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0)
      else $error("invalid point with nonzero coordinates");

   a_corr_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCALE_XY |-> dist_ff <= e_ff.dist_mm)
      else $error("corrected distance above measured distance");

   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCALE_D |-> c_ff != '0 && c_ff <= C_MAX)
      else $error("correction factor out of range");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff != ST_IDLE)
      else $error("item popped but back stayed idle");
`endif

endmodule

// ----- rtl/core/zone_depth_to_point_projection.sv -----
// zone_depth_to_point_projection: top level, configuration registers and the
// front / queue / back pipeline; depends on zdp_pkg, zdp_front, zdp_queue, zdp_back
//
//   channel   ports          handshake         payload
//   request   req_*          req_valid/stall   zone_distance, frame_start
//   response  rsp_*          rsp_valid/stall   point x/y/z, valid, zone, sensor, last
//   config    csr_*          csr_wr_en         csr_index, csr_data
//
// a valid zone goes through slope division, the 2^56/q reciprocal and 16 square root
// bit steps in the back end between pop and the result register; perpendicular mode
// skips squares, reciprocal, root and distance scaling, and a non-positive distance
// goes straight from the pop to the result register.
// the front accepts into a two-entry queue, so it takes items while the back works.
// reset clears counters, queue, state and configuration registers to their defaults.
// a stalled result waits in the output register while the next item is computed.
module zone_depth_to_point_projection (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [15:0]                   req_zone_distance,
   input  logic                                 req_frame_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [19:0]                   rsp_point_x,
   output logic signed [19:0]                   rsp_point_y,
   output logic [14:0]                          rsp_point_z,
   output logic                                 rsp_point_valid,
   output logic [7:0]                           rsp_zone_number,
   output logic [7:0]                           rsp_source_sensor,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_wr_en,
   input  logic [zdp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [zdp_pkg::CSR_DATA_W-1:0]       csr_data
);

   logic [4:0]  columns_ff, rows_ff;
   logic [15:0] tan_x_ff, tan_y_ff;
   logic        inv_h_ff, inv_v_ff, perp_ff;
   logic [7:0]  sensor_ff;

   zdp_pkg::cfg_type       cfg;
   zdp_pkg::zdp_entry_type entry, head;
   logic push, pop, empty, full;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= 5'd8;
         rows_ff    <= 5'd8;
         tan_x_ff   <= 16'd4096;
         tan_y_ff   <= 16'd4096;
         inv_h_ff   <= 1'b0;
         inv_v_ff   <= 1'b0;
         perp_ff    <= 1'b0;
         sensor_ff  <= 8'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            zdp_pkg::CSR_COLUMNS: columns_ff <= csr_data[4:0];
            zdp_pkg::CSR_ROWS:    rows_ff    <= csr_data[4:0];
            zdp_pkg::CSR_TAN_X:   tan_x_ff   <= csr_data;
            zdp_pkg::CSR_TAN_Y:   tan_y_ff   <= csr_data;
            zdp_pkg::CSR_INV_H:   inv_h_ff   <= csr_data[0];
            zdp_pkg::CSR_INV_V:   inv_v_ff   <= csr_data[0];
            zdp_pkg::CSR_PERP:    perp_ff    <= csr_data[0];
            zdp_pkg::CSR_SENSOR:  sensor_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.cols   = zdp_pkg::clamp_count(columns_ff, zdp_pkg::COUNT_W'(zdp_pkg::MAX_COLUMNS));
      cfg.rows   = zdp_pkg::clamp_count(rows_ff, zdp_pkg::COUNT_W'(zdp_pkg::MAX_ROWS));
      cfg.tan_x  = tan_x_ff;
      cfg.tan_y  = tan_y_ff;
      cfg.inv_h  = inv_h_ff;
      cfg.inv_v  = inv_v_ff;
      cfg.perp   = perp_ff;
      cfg.sensor = sensor_ff;
   end

   assign req_stall = full;
   assign push      = req_valid && !full;

   zdp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .push          (push),
      .zone_distance (req_zone_distance),
      .frame_start   (req_frame_start),
      .entry         (entry)
   );

   zdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   zdp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .head              (head),
      .empty             (empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_point_z       (rsp_point_z),
      .rsp_point_valid   (rsp_point_valid),
      .rsp_zone_number   (rsp_zone_number),
      .rsp_source_sensor (rsp_source_sensor),
      .rsp_frame_last    (rsp_frame_last)
   );

endmodule
